// ----- src/todlms_pkg.sv -----
// ----------------------------------------------------------------------------
// todlms_pkg
// Shared types and constants for the time-of-day lamp mode sequencer.
// ----------------------------------------------------------------------------
package todlms_pkg;

  // Field widths
  localparam int unsigned TimeWidth  = 17;
  localparam int unsigned TickWidth  = 16;
  localparam int unsigned ModeWidth  = 3;
  localparam int unsigned EdgesWidth = 3;
  localparam int unsigned IdxWidth   = 3;
  localparam int unsigned NumEdges   = 6;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataWidth  = 24;
  localparam int unsigned OutDataWidth = 8;

  // Countdown width default
  localparam int unsigned CountWidthDefault = 16;

  // Register reset values
  localparam logic [TimeWidth-1:0] FirstEdgeReset  = 17'd28800;
  localparam logic [TimeWidth-1:0] SecondEdgeReset = 17'd36000;
  localparam logic [TimeWidth-1:0] ThirdEdgeReset  = 17'd43200;
  localparam logic [TimeWidth-1:0] FourthEdgeReset = 17'd57600;
  localparam logic [TimeWidth-1:0] FifthEdgeReset  = 17'd64800;
  localparam logic [TimeWidth-1:0] SixthEdgeReset  = 17'd72000;
  localparam logic [TickWidth-1:0] ResetTicksReset = 16'd10000;
  localparam logic [TickWidth-1:0] PulseTicksReset = 16'd500;

  // Register indexes
  typedef enum logic [IdxWidth-1:0] {
    REG_FIRST_EDGE  = 3'd0,
    REG_SECOND_EDGE = 3'd1,
    REG_THIRD_EDGE  = 3'd2,
    REG_FOURTH_EDGE = 3'd3,
    REG_FIFTH_EDGE  = 3'd4,
    REG_SIXTH_EDGE  = 3'd5,
    REG_RESET_TICKS = 3'd6,
    REG_PULSE_TICKS = 3'd7
  } reg_idx_t;

  // Lamp modes
  typedef enum logic [ModeWidth-1:0] {
    MODE_OFF     = 3'd0,
    MODE_6K5     = 3'd1,
    MODE_4K0     = 3'd2,
    MODE_2K7     = 3'd3,
    MODE_UNKNOWN = 3'd4
  } mode_t;

  // Toggle counts per mode
  localparam logic [EdgesWidth-1:0] Edges6k5 = 3'd5;
  localparam logic [EdgesWidth-1:0] Edges4k0 = 3'd3;
  localparam logic [EdgesWidth-1:0] Edges2k7 = 3'd1;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_RESET = 3'b010,
    PH_PULSE = 3'b100
  } phase_t;

endpackage

// ----- src/time_of_day_lamp_mode_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// time_of_day_lamp_mode_sequencer_top
// Maps the time of day to a lamp mode and drives the reset/pulse sequence.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata: day_seconds
// m_*       out        m_tvalid/m_tready  m_tdata: switch_on, lamp_mode,
//                                                  mode_changed, busy_res
// cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One tick per cycle: the window compares and one countdown step sit between
// the state registers and the result register, so the result appears the
// cycle after the transfer. The result register frees as it is taken, so a
// stalled m side holds s_tready low only while a result still waits.
// rst clears the registers to their defaults, mode to unknown, sequencer idle.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module time_of_day_lamp_mode_sequencer_top #(
  parameter int unsigned COUNT_WIDTH = todlms_pkg::CountWidthDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata: [16:0] day_seconds, [23:17] zero
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [todlms_pkg::InDataWidth-1:0]  s_tdata,
  // m_tdata: [0] switch_on, [3:1] lamp_mode, [4] mode_changed, [5] busy_res,
  //          [7:6] zero
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [todlms_pkg::OutDataWidth-1:0] m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [todlms_pkg::IdxWidth-1:0]     cfg_index,
  input  logic [todlms_pkg::TimeWidth-1:0]    cfg_data
);
  import todlms_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;

  // Configuration registers
  logic [TimeWidth-1:0] edge_reg [NumEdges];
  logic [TickWidth-1:0] reset_ticks;
  logic [TickWidth-1:0] pulse_ticks;

  // Sequencer state
  mode_t                 current_mode, current_mode_next;
  phase_t                phase, phase_next;
  logic [CW-1:0]         countdown, countdown_next;
  logic [EdgesWidth-1:0] edges_left, edges_left_next;
  logic                  switch_level, switch_level_next;
  logic                  changed_next;

  // Result register
  logic                  out_valid;
  logic [OutDataWidth-1:0] out_data;

  logic [TimeWidth-1:0]  day_seconds;
  logic                  in_xfer;
  mode_t                 mode_calc;
  logic [CW-1:0]         reset_load, pulse_load;
  logic [CW-1:0]         reset_masked, pulse_masked;
  logic [CW-1:0]         count_dec;

  assign cfg_ready   = 1'b1;
  assign day_seconds = s_tdata[TimeWidth-1:0];
  assign s_tready    = !out_valid || m_tready;
  assign in_xfer     = s_tvalid && s_tready;
  assign m_tvalid    = out_valid;
  assign m_tdata     = out_data;

  // Fit the 16-bit tick registers to the countdown width
  if (CW >= TickWidth) begin : g_wide
    assign reset_masked = CW'(reset_ticks);
    assign pulse_masked = CW'(pulse_ticks);
  end else begin : g_narrow
    assign reset_masked = reset_ticks[CW-1:0];
    assign pulse_masked = pulse_ticks[CW-1:0];
  end

  // A zero load counts as one
  assign reset_load = (reset_masked == '0) ? CW'(1) : reset_masked;
  assign pulse_load = (pulse_masked == '0) ? CW'(1) : pulse_masked;
  assign count_dec  = (countdown == '0) ? '0 : countdown - CW'(1);

  // Window lookup, first match wins
  always_comb begin
    priority if (day_seconds >= edge_reg[0] && day_seconds < edge_reg[1]) begin
      mode_calc = MODE_6K5;
    end else if (day_seconds >= edge_reg[1] && day_seconds < edge_reg[2]) begin
      mode_calc = MODE_4K0;
    end else if (day_seconds >= edge_reg[2] && day_seconds < edge_reg[3]) begin
      mode_calc = MODE_2K7;
    end else if (day_seconds >= edge_reg[3] && day_seconds < edge_reg[4]) begin
      mode_calc = MODE_4K0;
    end else if (day_seconds >= edge_reg[4] && day_seconds < edge_reg[5]) begin
      mode_calc = MODE_6K5;
    end else begin
      mode_calc = MODE_OFF;
    end
  end

  // Next state for one tick
  always_comb begin
    current_mode_next = current_mode;
    phase_next        = phase;
    countdown_next    = countdown;
    edges_left_next   = edges_left;
    switch_level_next = switch_level;
    changed_next      = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (mode_calc != current_mode) begin
          current_mode_next = mode_calc;
          changed_next      = 1'b1;
          switch_level_next = 1'b0;
          if (mode_calc != MODE_OFF) begin
            phase_next     = PH_RESET;
            countdown_next = reset_load;
            unique case (mode_calc)
              MODE_6K5: edges_left_next = Edges6k5;
              MODE_4K0: edges_left_next = Edges4k0;
              default:  edges_left_next = Edges2k7;
            endcase
          end
        end
      end
      PH_RESET, PH_PULSE: begin
        countdown_next = count_dec;
        if (count_dec == '0) begin
          switch_level_next = !switch_level;
          edges_left_next   = (edges_left == '0) ? '0 : edges_left - EdgesWidth'(1);
          if (edges_left_next == '0) begin
            phase_next = PH_IDLE;
          end else begin
            phase_next     = PH_PULSE;
            countdown_next = pulse_load;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_reg[0] <= FirstEdgeReset;
      edge_reg[1] <= SecondEdgeReset;
      edge_reg[2] <= ThirdEdgeReset;
      edge_reg[3] <= FourthEdgeReset;
      edge_reg[4] <= FifthEdgeReset;
      edge_reg[5] <= SixthEdgeReset;
      reset_ticks <= ResetTicksReset;
      pulse_ticks <= PulseTicksReset;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FIRST_EDGE:  edge_reg[0] <= cfg_data;
        REG_SECOND_EDGE: edge_reg[1] <= cfg_data;
        REG_THIRD_EDGE:  edge_reg[2] <= cfg_data;
        REG_FOURTH_EDGE: edge_reg[3] <= cfg_data;
        REG_FIFTH_EDGE:  edge_reg[4] <= cfg_data;
        REG_SIXTH_EDGE:  edge_reg[5] <= cfg_data;
        REG_RESET_TICKS: reset_ticks <= cfg_data[TickWidth-1:0];
        REG_PULSE_TICKS: pulse_ticks <= cfg_data[TickWidth-1:0];
        default: ;
      endcase
    end
  end

  // Advance sequencer state on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode <= MODE_UNKNOWN;
      phase        <= PH_IDLE;
      countdown    <= '0;
      edges_left   <= '0;
      switch_level <= 1'b0;
    end else if (in_xfer) begin
      current_mode <= current_mode_next;
      phase        <= phase_next;
      countdown    <= countdown_next;
      edges_left   <= edges_left_next;
      switch_level <= switch_level_next;
    end
  end

  // Hold the result until the output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data <= {2'b00, (phase_next != PH_IDLE), changed_next,
                   current_mode_next, switch_level_next};
    end
  end

endmodule

// ----- tb/lamp_sequence_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamp_sequence_checker
// Watches the tick, result and register channels of the lamp mode sequencer,
// predicts every result from its own copy of the registers and sequencer
// state, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module lamp_sequence_checker
  import todlms_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [InDataWidth-1:0]  s_tdata,
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic [OutDataWidth-1:0] m_tdata,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [IdxWidth-1:0]     cfg_index,
  input  logic [TimeWidth-1:0]    cfg_data,
  output int                      waiting,
  output int                      errors,
  output int                      checked
);

  localparam int unsigned CountW = CountWidthDefault;

  // Result layout, highest bit first, as it sits in m_tdata[5:0]
  typedef struct packed {
    logic  busy_res;
    logic  mode_changed;
    mode_t lamp_mode;
    logic  switch_on;
  } lamp_out_t;

  // Register copy
  logic [TimeWidth-1:0] edge_at [NumEdges];
  logic [TickWidth-1:0] reset_len;
  logic [TickWidth-1:0] pulse_len;

  // Sequencer copy
  mode_t                 lamp_mode_q;
  phase_t                phase_q;
  logic [CountW-1:0]     countdown_q;
  logic [EdgesWidth-1:0] toggles_left;
  logic                  switch_q;

  lamp_out_t lamp_out_q [$];

  // Windows are half-open and tested in order; the first hit wins
  function automatic mode_t window_mode(input logic [TimeWidth-1:0] t);
    if (t >= edge_at[0] && t < edge_at[1]) return MODE_6K5;
    if (t >= edge_at[1] && t < edge_at[2]) return MODE_4K0;
    if (t >= edge_at[2] && t < edge_at[3]) return MODE_2K7;
    if (t >= edge_at[3] && t < edge_at[4]) return MODE_4K0;
    if (t >= edge_at[4] && t < edge_at[5]) return MODE_6K5;
    return MODE_OFF;
  endfunction

  // A zero length counts as one tick
  function automatic logic [CountW-1:0] count_len(input logic [TickWidth-1:0] v);
    logic [CountW-1:0] x;
    x = CountW'(v);
    return (x == '0) ? CountW'(1) : x;
  endfunction

  // Advance the sequencer by one tick and return the result it shows
  task automatic step_lamp(input logic [TimeWidth-1:0] t, output lamp_out_t r);
    mode_t m;
    logic  changed;
    changed = 1'b0;
    if (phase_q == PH_IDLE) begin
      m = window_mode(t);
      if (m != lamp_mode_q) begin
        lamp_mode_q = m;
        changed = 1'b1;
        switch_q = 1'b0;
        if (m != MODE_OFF) begin
          phase_q = PH_RESET;
          countdown_q = count_len(reset_len);
          toggles_left = (m == MODE_6K5) ? Edges6k5 :
                         (m == MODE_4K0) ? Edges4k0 : Edges2k7;
        end
      end
    end else begin
      // time of day is ignored while a sequence runs
      if (countdown_q != '0) countdown_q = countdown_q - 1'b1;
      if (countdown_q == '0) begin
        switch_q = ~switch_q;
        if (toggles_left != '0) toggles_left = toggles_left - 1'b1;
        if (toggles_left == '0) begin
          phase_q = PH_IDLE;
        end else begin
          phase_q = PH_PULSE;
          countdown_q = count_len(pulse_len);
        end
      end
    end
    r.switch_on    = switch_q;
    r.lamp_mode    = lamp_mode_q;
    r.mode_changed = changed;
    r.busy_res     = (phase_q != PH_IDLE);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 30) begin
      $display("[%0t] result %0d: %s is %0d, should be %0d", $time, checked, what, got, want);
    end
  endtask

  // Track registers, predict on each tick transfer, check each result transfer
  always @(posedge clk) begin : watch
    lamp_out_t want;
    lamp_out_t got;
    if (rst) begin
      edge_at[0]   = FirstEdgeReset;
      edge_at[1]   = SecondEdgeReset;
      edge_at[2]   = ThirdEdgeReset;
      edge_at[3]   = FourthEdgeReset;
      edge_at[4]   = FifthEdgeReset;
      edge_at[5]   = SixthEdgeReset;
      reset_len    = ResetTicksReset;
      pulse_len    = PulseTicksReset;
      lamp_mode_q  = MODE_UNKNOWN;
      phase_q      = PH_IDLE;
      countdown_q  = '0;
      toggles_left = '0;
      switch_q     = 1'b0;
      lamp_out_q.delete();
      waiting      = 0;
      errors       = 0;
      checked      = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_FIRST_EDGE, REG_SECOND_EDGE, REG_THIRD_EDGE,
          REG_FOURTH_EDGE, REG_FIFTH_EDGE, REG_SIXTH_EDGE: begin
            edge_at[cfg_index] = cfg_data;
          end
          REG_RESET_TICKS: reset_len = cfg_data[TickWidth-1:0];
          REG_PULSE_TICKS: pulse_len = cfg_data[TickWidth-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        step_lamp(s_tdata[TimeWidth-1:0], want);
        lamp_out_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = lamp_out_t'(m_tdata[5:0]);
        if (lamp_out_q.size() == 0) begin
          report_mismatch("result with nothing pending, data", int'(m_tdata), 0);
        end else begin
          want = lamp_out_q.pop_front();
          if (got.switch_on !== want.switch_on)
            report_mismatch("switch_on", int'(got.switch_on), int'(want.switch_on));
          if (got.lamp_mode !== want.lamp_mode)
            report_mismatch("lamp_mode", int'(got.lamp_mode), int'(want.lamp_mode));
          if (got.mode_changed !== want.mode_changed)
            report_mismatch("mode_changed", int'(got.mode_changed), int'(want.mode_changed));
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
          if (m_tdata[7:6] !== 2'b00)
            report_mismatch("pad bits", int'(m_tdata[7:6]), 0);
          checked++;
        end
      end
      waiting = lamp_out_q.size();
    end
  end

endmodule

// ----- tb/time_of_day_lamp_mode_sequencer_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_day_lamp_mode_sequencer_top_test
// Drives day-second ticks and register writes into the lamp mode sequencer
// under random source gaps and sink stalls: a directed walk through every
// window, random edge layouts and tick lengths, then the longest tick lengths
// at full rate. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module time_of_day_lamp_mode_sequencer_top_test;
  import todlms_pkg::*;

  localparam int     RandomItems = 440;
  localparam int     NumRegs     = 8;
  localparam int     AnyTime     = -1;
  localparam int     MaxTime     = 17'h1FFFF;
  localparam int     DayLast     = 86399;
  // Bound for the slowest run, which is mostly sink stalls
  localparam longint LimitNs     = 64'd2_000_000;

  logic                    clk;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [InDataWidth-1:0]  s_tdata   = '0;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [OutDataWidth-1:0] m_tdata;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [IdxWidth-1:0]     cfg_index = '0;
  logic [TimeWidth-1:0]    cfg_data  = '0;

  int waiting;
  int errors;
  int checked;

  // Stimulus bookkeeping
  bit                   quiet = 1'b0;
  int                   burst_left = 0;
  int                   items_sent = 0;
  int                   settings_used = 0;
  logic [TimeWidth-1:0] reg_val [NumRegs];
  bit                   reg_pick [NumRegs];

  // Sink stall pattern
  logic [15:0] stall_pat = '1;
  int          pat_age = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  time_of_day_lamp_mode_sequencer_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lamp_sequence_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .waiting   (waiting),
    .errors    (errors),
    .checked   (checked)
  );

  // Sink: replay a 16-bit ready pattern, redrawn each time it runs out
  always @(posedge clk) begin
    if (quiet) begin
      m_tready <= 1'b1;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = '1;
          1:       stall_pat = 16'($urandom);
          2:       stall_pat = 16'($urandom & $urandom);
          default: stall_pat = 16'($urandom | $urandom);
        endcase
        stall_pat[$urandom_range(0, 15)] = 1'b1;
      end
      m_tready <= stall_pat[pat_age];
      pat_age = (pat_age + 1) % 16;
    end
  end

  // Source: one tick transfer, with a random gap at the start of each burst
  task automatic send_tick(input logic [TimeWidth-1:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= InDataWidth'(t);
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Hold the source until every result is in, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (waiting != 0);
    repeat (3) @(posedge clk);
  endtask

  // Write the picked registers, lowest index first
  task automatic write_picked();
    for (int i = 0; i < NumRegs; i++) begin
      if (reg_pick[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= reg_idx_t'(i);
        cfg_data  <= reg_val[i];
        do @(posedge clk); while (!cfg_ready);
      end
      reg_pick[i] = 1'b0;
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly short countdowns so sequences finish and windows get re-evaluated
  function automatic logic [TimeWidth-1:0] tick_len();
    case ($urandom_range(0, 9))
      0:       return '0;                                   // counts as one
      1:       return 17'h10000 | 17'($urandom_range(0, 3)); // upper bit dropped
      default: return 17'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin : stimulus
    int                   directed_t [$];
    int                   edge_q [$];
    int                   random_sent;
    int                   n;
    int                   k;
    int                   e;
    logic [TimeWidth-1:0] t;

    // Walk every window in order, with enough ticks to finish each sequence
    directed_t = '{0, DayLast, 28800, AnyTime, AnyTime, AnyTime, AnyTime, AnyTime,
                   36000, AnyTime, AnyTime, AnyTime, 43200, AnyTime,
                   57600, AnyTime, AnyTime, AnyTime,
                   64800, AnyTime, AnyTime, AnyTime, AnyTime, AnyTime, 72000};
    random_sent = 0;
    reg_val = '{FirstEdgeReset, SecondEdgeReset, ThirdEdgeReset, FourthEdgeReset,
                FifthEdgeReset, SixthEdgeReset, 17'(ResetTicksReset),
                17'(PulseTicksReset)};
    foreach (reg_pick[i]) reg_pick[i] = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: default edges, zero reset length, pulse length with only bit 16
    reg_val[REG_RESET_TICKS]  = '0;
    reg_pick[REG_RESET_TICKS] = 1'b1;
    reg_val[REG_PULSE_TICKS]  = 17'h10000;
    reg_pick[REG_PULSE_TICKS] = 1'b1;
    write_picked();
    foreach (directed_t[i]) begin
      t = (directed_t[i] == AnyTime) ? 17'($urandom_range(0, MaxTime)) : 17'(directed_t[i]);
      send_tick(t);
    end

    // Random settings, each followed by a burst of ticks
    while (random_sent < RandomItems) begin
      drain();
      if ($urandom_range(0, 9) < 7) begin
        edge_q.delete();
        repeat (NumEdges) edge_q.push_back($urandom_range(0, DayLast));
        edge_q.sort();
        case ($urandom_range(0, 5))
          // scrambled, may run past the end of the day
          0: foreach (edge_q[i]) edge_q[i] = $urandom_range(0, MaxTime);
          // every pair out of order: all windows empty
          1: edge_q.reverse();
          // two equal edges leave one window empty
          2: begin
            k = $urandom_range(1, NumEdges - 1);
            edge_q[k] = edge_q[k - 1];
          end
          3: begin
            edge_q[0] = 0;
            edge_q[NumEdges - 1] = MaxTime;
          end
          default: ;
        endcase
        foreach (edge_q[i]) begin
          if ($urandom_range(0, 7) != 0) begin
            reg_val[i]  = 17'(edge_q[i]);
            reg_pick[i] = 1'b1;
          end
        end
      end
      if ($urandom_range(0, 4) < 3) begin
        reg_val[REG_RESET_TICKS]  = tick_len();
        reg_pick[REG_RESET_TICKS] = 1'b1;
      end
      if ($urandom_range(0, 4) < 3) begin
        reg_val[REG_PULSE_TICKS]  = tick_len();
        reg_pick[REG_PULSE_TICKS] = 1'b1;
      end
      write_picked();
      quiet = ($urandom_range(0, 5) == 0);
      n = $urandom_range(20, 60);
      repeat (n) begin
        case ($urandom_range(0, 9))
          // just around an edge
          0, 1, 2, 3: begin
            e = int'(reg_val[$urandom_range(0, NumEdges - 1)]) + $urandom_range(0, 2) - 1;
            t = 17'(e);
          end
          4, 5, 6: t = 17'($urandom_range(0, DayLast));
          7:       t = 17'($urandom_range(0, MaxTime));
          8:       t = $urandom_range(0, 1) ? 17'(DayLast) : '0;
          default: t = 17'($urandom_range(DayLast + 1, MaxTime));
        endcase
        send_tick(t);
      end
      random_sent += n;
    end

    // Longest tick lengths at full rate; first settle into off with short lengths
    drain();
    quiet = 1'b1;
    reg_val = '{FirstEdgeReset, SecondEdgeReset, ThirdEdgeReset, FourthEdgeReset,
                FifthEdgeReset, SixthEdgeReset, 17'd1, 17'd1};
    foreach (reg_pick[i]) reg_pick[i] = 1'b1;
    write_picked();
    repeat (40) send_tick('0);

    // Load the longest reset and pulse lengths and run into the reset phase
    drain();
    reg_val[REG_RESET_TICKS]  = 17'hFFFF;
    reg_pick[REG_RESET_TICKS] = 1'b1;
    reg_val[REG_PULSE_TICKS]  = 17'hFFFF;
    reg_pick[REG_PULSE_TICKS] = 1'b1;
    write_picked();
    send_tick(17'(28800));
    repeat (20) send_tick(17'($urandom_range(0, MaxTime)));

    // Wait out the last results, bounded, then idle for any strays
    s_tvalid <= 1'b0;
    for (k = 0; k < 100000 && waiting != 0; k++) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d ticks (%0d random) under %0d register settings, %0d results compared.",
             items_sent, random_sent, settings_used, checked);
    $display("Covered all windows, empty and out-of-day edges, zero and 65535-tick lengths.");
    if (waiting != 0) $display("%0d results never arrived", waiting);
    if (errors == 0 && waiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LimitNs);
    $display("Timed out with %0d results still pending", waiting);
    $display("== FAIL ==");
    $finish;
  end

endmodule
